[hw/rtl/ps2_scancode_to_ascii_unit_assert.svh]
// assertion macros for the ps2 scancode translator
// used by ps2_scancode_to_ascii_unit, no other dependencies
`ifndef PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PS2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2a assertion failed");

// next-cycle implication, checked outside reset
`define PS2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2a assertion failed");

`endif

[hw/rtl/ps2a_pkg.sv]
// types, key codes and layout tables for the ps2 set-1 to ascii translator
// no dependencies
package ps2a_pkg;

  localparam int ScanW = 8;
  localparam int CodeW = 7;
  localparam int CharW = 7;
  localparam int MoveW = 3;
  localparam int OutW  = 16;

  localparam logic [CodeW-1:0] SC_LSHIFT    = 7'h2A;
  localparam logic [CodeW-1:0] SC_RSHIFT    = 7'h36;
  localparam logic [CodeW-1:0] SC_LCTRL     = 7'h1D;
  localparam logic [CodeW-1:0] SC_LALT      = 7'h38;
  localparam logic [CodeW-1:0] SC_CAPS      = 7'h3A;
  localparam logic [CodeW-1:0] SC_BACKSPACE = 7'h0E;
  localparam logic [CodeW-1:0] SC_UP        = 7'h48;
  localparam logic [CodeW-1:0] SC_DOWN      = 7'h50;
  localparam logic [CodeW-1:0] SC_LEFT      = 7'h4B;
  localparam logic [CodeW-1:0] SC_RIGHT     = 7'h4D;

  localparam logic [CharW-1:0] CH_NONE      = 7'h00;
  localparam logic [CharW-1:0] CH_BACKSPACE = 7'h08;

  localparam logic [MoveW-1:0] MOVE_NONE  = 3'd0;
  localparam logic [MoveW-1:0] MOVE_UP    = 3'd1;
  localparam logic [MoveW-1:0] MOVE_DOWN  = 3'd2;
  localparam logic [MoveW-1:0] MOVE_LEFT  = 3'd3;
  localparam logic [MoveW-1:0] MOVE_RIGHT = 3'd4;

  // result item, msb first so char_code lands in the low bits
  typedef struct packed {
    logic             caps_active;
    logic             alt_held;
    logic             ctrl_held;
    logic             shift_held;
    logic [MoveW-1:0] cursor_move;
    logic [CharW-1:0] char_code;
  } out_item_t;

  function automatic logic [CharW-1:0] rom_plain(input logic [CodeW-1:0] code);
    logic [CharW-1:0] c;
    case (code)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08; 7'h0F: c = 7'h09; 7'h10: c = 7'h71; 7'h11: c = 7'h77;
      7'h12: c = 7'h65; 7'h13: c = 7'h72; 7'h14: c = 7'h74; 7'h15: c = 7'h79;
      7'h16: c = 7'h75; 7'h17: c = 7'h69; 7'h18: c = 7'h6F; 7'h19: c = 7'h70;
      7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D; 7'h1C: c = 7'h0A; 7'h1E: c = 7'h61;
      7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67;
      7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C;
      7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] rom_shifted(input logic [CodeW-1:0] code);
    logic [CharW-1:0] c;
    case (code)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h0E: c = 7'h08; 7'h0F: c = 7'h09; 7'h10: c = 7'h51; 7'h11: c = 7'h57;
      7'h12: c = 7'h45; 7'h13: c = 7'h52; 7'h14: c = 7'h54; 7'h15: c = 7'h59;
      7'h16: c = 7'h55; 7'h17: c = 7'h49; 7'h18: c = 7'h4F; 7'h19: c = 7'h50;
      7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D; 7'h1C: c = 7'h0A; 7'h1E: c = 7'h41;
      7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47;
      7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C;
      7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C;
      7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
      7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // flip bit 5 of letters only
  function automatic logic [CharW-1:0] swap_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[7'h61:7'h7A], [7'h41:7'h5A]}) begin
      r = c ^ 7'h20;
    end
    return r;
  endfunction

endpackage

[hw/rtl/ps2_scancode_to_ascii_unit.sv]
// ps2 set-1 scancode to ascii translator, input register and result register
// depends on ps2a_pkg and ps2_scancode_to_ascii_unit_assert.svh
//
// One scancode byte in, one result out, one transfer per cycle sustained
// while out_tready is high. A byte is captured in an input register; its
// table lookup, case swap and modifier update then run in one pass of logic
// into the result register, from which the result transfers. Shift, ctrl,
// alt and caps lock flags live in this block and are reported with every
// result as they stand after that byte. Bytes with bit 7 set are releases and
// never give a character; arrow presses give a cursor code and no character.
// While both registers hold an item, in_tready follows out_tready
// combinationally.
`include "ps2_scancode_to_ascii_unit_assert.svh"

module ps2_scancode_to_ascii_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ps2a_pkg::ScanW-1:0] in_tdata,   // [7:0] scan_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [6:0] char_code, [9:7] cursor_move, [10] shift_held, [11] ctrl_held,
  // [12] alt_held, [13] caps_active, [15:14] zero
  output logic [ps2a_pkg::OutW-1:0]  out_tdata
);
  import ps2a_pkg::*;

  logic             in_valid_r;
  logic [ScanW-1:0] in_byte_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;
  logic             out_valid_r;
  logic             shift_r, ctrl_r, alt_r, caps_r;
  logic             shift_nxt, ctrl_nxt, alt_nxt, caps_nxt;
  logic             stage_adv;
  logic             stage_fire;
  logic [CodeW-1:0] code;
  logic             release_bit;
  logic [CharW-1:0] lookup;

  assign stage_adv  = !out_valid_r || out_tready;
  assign stage_fire = in_valid_r && stage_adv;
  assign in_tready  = !in_valid_r || stage_adv;

  assign code        = in_byte_r[CodeW-1:0];
  assign release_bit = in_byte_r[ScanW-1];

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    caps_nxt  = caps_r;
    out_item_nxt.char_code   = CH_NONE;
    out_item_nxt.cursor_move = MOVE_NONE;
    lookup = shift_r ? rom_shifted(code) : rom_plain(code);
    if (release_bit) begin
      if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_nxt = 1'b0;
      end else if (code == SC_LCTRL) begin
        ctrl_nxt = 1'b0;
      end else if (code == SC_LALT) begin
        alt_nxt = 1'b0;
      end
    end else begin
      case (code)
        SC_LSHIFT, SC_RSHIFT: shift_nxt = 1'b1;
        SC_LCTRL:     ctrl_nxt = 1'b1;
        SC_LALT:      alt_nxt  = 1'b1;
        SC_CAPS:      caps_nxt = !caps_r;
        SC_BACKSPACE: out_item_nxt.char_code   = CH_BACKSPACE;
        SC_UP:        out_item_nxt.cursor_move = MOVE_UP;
        SC_DOWN:      out_item_nxt.cursor_move = MOVE_DOWN;
        SC_LEFT:      out_item_nxt.cursor_move = MOVE_LEFT;
        SC_RIGHT:     out_item_nxt.cursor_move = MOVE_RIGHT;
        default: begin
          out_item_nxt.char_code = caps_r ? swap_case(lookup) : lookup;
        end
      endcase
    end
    out_item_nxt.shift_held  = shift_nxt;
    out_item_nxt.ctrl_held   = ctrl_nxt;
    out_item_nxt.alt_held    = alt_nxt;
    out_item_nxt.caps_active = caps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= 1'b0;
      ctrl_r      <= 1'b0;
      alt_r       <= 1'b0;
      caps_r      <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (stage_adv) begin
        out_valid_r <= in_valid_r;
      end
      if (stage_fire) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        alt_r   <= alt_nxt;
        caps_r  <= caps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (stage_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutW - $bits(out_item_t))'(0), out_item_r};

  `PS2A_ASSERT_NOW(a_move_no_char, clk, rst_n, out_valid_r,
    out_item_r.cursor_move == MOVE_NONE || out_item_r.char_code == CH_NONE)
  `PS2A_ASSERT_NOW(a_move_range, clk, rst_n, out_valid_r,
    out_item_r.cursor_move <= MOVE_RIGHT)
  `PS2A_ASSERT_NEXT(a_release_no_char, clk, rst_n, stage_fire && release_bit,
    out_item_r.char_code == CH_NONE && out_item_r.cursor_move == MOVE_NONE)
  `PS2A_ASSERT_NEXT(a_caps_only_on_press, clk, rst_n,
    !(stage_fire && !release_bit && code == SC_CAPS), caps_r == $past(caps_r))
  `PS2A_ASSERT_NOW(a_flags_reported, clk, rst_n, out_valid_r && !in_valid_r,
    out_item_r.shift_held == shift_r && out_item_r.caps_active == caps_r)

endmodule

[dv/ps2_scancode_to_ascii_unit_checker.sv]
// result checker for ps2_scancode_to_ascii_unit: tracks the modifier flags from the
// scancode stream, predicts every result and compares it field by field
// depends on ps2a_pkg for widths, key codes and the result layout
module ps2_scancode_to_ascii_unit_checker
  import ps2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [ScanW-1:0] in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OutW-1:0]  out_tdata,
  output int               mismatch_count,
  output int               pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemW = $bits(out_item_t);

  logic [CharW-1:0] plain_keymap   [128];
  logic [CharW-1:0] shifted_keymap [128];
  logic             shift_on, ctrl_on, alt_on, caps_on;
  out_item_t        predicted_q [$];

  task automatic load_row(input bit shifted, input int base, input string chars);
    for (int i = 0; i < chars.len(); i++) begin
      if (shifted) begin
        shifted_keymap[base + i] = CharW'(chars[i]);
      end else begin
        plain_keymap[base + i] = CharW'(chars[i]);
      end
    end
  endtask

  // us layout, set-1 make codes
  initial begin
    for (int i = 0; i < 128; i++) begin
      plain_keymap[i]   = CH_NONE;
      shifted_keymap[i] = CH_NONE;
    end
    load_row(1'b0, 'h02, "1234567890-=");
    load_row(1'b0, 'h10, "qwertyuiop[]");
    load_row(1'b0, 'h1E, "asdfghjkl;'");
    load_row(1'b0, 'h2B, "\\zxcvbnm,./");
    load_row(1'b1, 'h02, "!@#$%^&*()_+");
    load_row(1'b1, 'h10, "QWERTYUIOP{}");
    load_row(1'b1, 'h1E, "ASDFGHJKL:\"~");
    load_row(1'b1, 'h2B, "|ZXCVBNM<>?");
    plain_keymap['h29] = 7'h60;
    for (int s = 0; s < 2; s++) begin
      load_row(s[0], 'h37, "*");
      load_row(s[0], 'h39, " ");
    end
    plain_keymap['h0E] = CH_BACKSPACE;  shifted_keymap['h0E] = CH_BACKSPACE;
    plain_keymap['h0F] = 7'h09;         shifted_keymap['h0F] = 7'h09;
    plain_keymap['h1C] = 7'h0A;         shifted_keymap['h1C] = 7'h0A;
  end

  // updates the flags and returns the result for one scancode byte
  function automatic out_item_t translate_scan(input logic [ScanW-1:0] scan);
    out_item_t        r;
    logic [CodeW-1:0] key;
    logic [CharW-1:0] c;
    r   = '0;
    key = scan[CodeW-1:0];
    if (scan[ScanW-1]) begin
      // break codes and prefixes only ever clear a modifier
      if (key == SC_LSHIFT || key == SC_RSHIFT) begin
        shift_on = 1'b0;
      end else if (key == SC_LCTRL) begin
        ctrl_on = 1'b0;
      end else if (key == SC_LALT) begin
        alt_on = 1'b0;
      end
    end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
      shift_on = 1'b1;
    end else if (key == SC_LCTRL) begin
      ctrl_on = 1'b1;
    end else if (key == SC_LALT) begin
      alt_on = 1'b1;
    end else if (key == SC_CAPS) begin
      caps_on = ~caps_on;
    end else if (key == SC_BACKSPACE) begin
      r.char_code = CH_BACKSPACE;
    end else if (key == SC_UP) begin
      r.cursor_move = MOVE_UP;
    end else if (key == SC_DOWN) begin
      r.cursor_move = MOVE_DOWN;
    end else if (key == SC_LEFT) begin
      r.cursor_move = MOVE_LEFT;
    end else if (key == SC_RIGHT) begin
      r.cursor_move = MOVE_RIGHT;
    end else begin
      c = shift_on ? shifted_keymap[key] : plain_keymap[key];
      if (caps_on && ((c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A))) begin
        c = c ^ 7'h20;
      end
      r.char_code = c;
    end
    r.shift_held  = shift_on;
    r.ctrl_held   = ctrl_on;
    r.alt_held    = alt_on;
    r.caps_active = caps_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("%0t ns: result error, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : track
    out_item_t want, got;
    if (!rst_n) begin
      mismatch_count = 0;
      shift_on = 1'b0;
      ctrl_on  = 1'b0;
      alt_on   = 1'b0;
      caps_on  = 1'b0;
      predicted_q.delete();
    end else begin
      // results first, so one that shows up in the same cycle as its input fails
      if (out_tvalid && out_tready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("transfer with nothing expected", int'(out_tdata), 0);
        end else begin
          want = predicted_q.pop_front();
          got  = out_item_t'(out_tdata[ItemW-1:0]);
          if (got.char_code !== want.char_code)
            report_mismatch("char_code", int'(got.char_code), int'(want.char_code));
          if (got.cursor_move !== want.cursor_move)
            report_mismatch("cursor_move", int'(got.cursor_move), int'(want.cursor_move));
          if (got.shift_held !== want.shift_held)
            report_mismatch("shift_held", int'(got.shift_held), int'(want.shift_held));
          if (got.ctrl_held !== want.ctrl_held)
            report_mismatch("ctrl_held", int'(got.ctrl_held), int'(want.ctrl_held));
          if (got.alt_held !== want.alt_held)
            report_mismatch("alt_held", int'(got.alt_held), int'(want.alt_held));
          if (got.caps_active !== want.caps_active)
            report_mismatch("caps_active", int'(got.caps_active), int'(want.caps_active));
          if (out_tdata[OutW-1:ItemW] !== '0)
            report_mismatch("pad bits", int'(out_tdata[OutW-1:ItemW]), 0);
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_q.push_back(translate_scan(in_tdata));
      end
    end
    pending_results = predicted_q.size();
  end

endmodule

[dv/ps2_scancode_to_ascii_unit_tb.sv]
// top of the ps2_scancode_to_ascii_unit testbench: clock, reset, scancode stimulus
// with bursty input and stalling output; checking lives in the checker module
// depends on ps2a_pkg, ps2_scancode_to_ascii_unit and ps2_scancode_to_ascii_unit_checker
module ps2_scancode_to_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2a_pkg::*;

  localparam int RandomItems = 1900;
  localparam int DrainCycles = 8;
  localparam logic [ScanW-1:0] EXT_PREFIX = 8'hE0;

  // receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;
  localparam int RX_HOLD     = 7;
  localparam int HoldCycles  = 80;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [ScanW-1:0] in_tdata   = '0;   // [7:0] scan_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [6:0] char_code, [9:7] cursor_move, [10] shift_held, [11] ctrl_held,
  // [12] alt_held, [13] caps_active, [15:14] zero
  logic [OutW-1:0]  out_tdata;
  int               mismatch_count;
  int               pending_results;
  int               items_sent = 0;
  int               burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ps2_scancode_to_ascii_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ps2_scancode_to_ascii_unit_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  function automatic logic [ScanW-1:0] press(input logic [CodeW-1:0] key);
    return {1'b0, key};
  endfunction

  function automatic logic [ScanW-1:0] lift(input logic [CodeW-1:0] key);
    return {1'b1, key};
  endfunction

  // offers one byte and returns at the edge where it transfers
  task automatic send_scan(input logic [ScanW-1:0] scan);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= scan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // a key with random content from the mapped range, now and then anywhere
  function automatic logic [CodeW-1:0] pick_key();
    return ($urandom_range(0, 3) == 0) ? CodeW'($urandom_range(0, 127))
                                       : CodeW'($urandom_range(1, 'h39));
  endfunction

  initial begin : receiver
    int seg, len, mode;
    seg = 0;
    forever begin
      // the fourth stretch always holds off long enough to back up the input
      mode = (seg == 3) ? RX_HOLD : $urandom_range(0, 7);
      if (mode > RX_PERIODIC && mode != RX_HOLD) mode = RX_ALWAYS;
      len  = (mode == RX_HOLD) ? HoldCycles : $urandom_range(20, 200);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        case (mode)
          RX_ALWAYS:   out_tready <= 1'b1;
          RX_RANDOM:   out_tready <= $urandom_range(0, 1);
          RX_SPARSE:   out_tready <= ($urandom_range(0, 4) == 0);
          RX_PERIODIC: out_tready <= (i % 3 != 0);
          default:     out_tready <= 1'b0;
        endcase
      end
      seg++;
    end
  end

  initial begin : stimulus
    logic [CodeW-1:0] key, modifier;
    logic [CodeW-1:0] arrows [4];
    logic [ScanW-1:0] directed_scans [$];
    arrows = '{SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT};
    directed_scans = {
      8'h00, press(7'h1E), press(SC_LSHIFT), press(7'h1E), press(SC_CAPS),
      press(7'h1E), press(7'h02), lift(SC_LSHIFT), press(7'h1E), press(SC_BACKSPACE),
      lift(SC_CAPS), press(SC_CAPS), press(SC_LSHIFT), press(SC_RSHIFT), lift(SC_RSHIFT),
      press(7'h10), press(SC_LCTRL), press(SC_LALT), EXT_PREFIX, press(SC_UP),
      press(SC_DOWN), press(SC_LEFT), press(SC_RIGHT), lift(SC_LCTRL), lift(SC_LALT),
      8'h7F, 8'hFF, press(7'h39)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_scans[i]) send_scan(directed_scans[i]);

    while (items_sent < directed_scans.size() + RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // a typed key, sometimes under shift, released with either shift
          key = pick_key();
          if ($urandom_range(0, 2) == 0) begin
            send_scan(press($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT));
            send_scan(press(key));
            send_scan(lift(key));
            send_scan(lift($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT));
          end else begin
            send_scan(press(key));
            send_scan(lift(key));
          end
        end
        5: begin
          modifier = $urandom_range(0, 1) ? SC_LCTRL : SC_LALT;
          key = pick_key();
          send_scan(press(modifier));
          send_scan(press(key));
          send_scan(lift(key));
          if ($urandom_range(0, 3) != 0) send_scan(lift(modifier));
        end
        6: begin
          send_scan(press(SC_CAPS));
          send_scan(lift(SC_CAPS));
        end
        7: begin
          // extended arrow: prefix then ordinary code
          key = arrows[$urandom_range(0, 3)];
          send_scan(EXT_PREFIX);
          send_scan(press(key));
          send_scan(EXT_PREFIX);
          send_scan(lift(key));
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_scan(ScanW'($urandom_range(0, 255)));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("ps2_scancode_to_ascii_unit: match");
    end else begin
      $display("ps2_scancode_to_ascii_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #8ms;
    $display("ps2_scancode_to_ascii_unit: mismatch");
    $finish;
  end

endmodule
